// ===== sv/ldt_pkg.sv =====
// Shared types and constants for the line departure tracker.
package ldt_pkg;

  localparam int unsigned PeriodW   = 8;
  localparam int unsigned SpacingW  = 8;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned RateW     = 24;
  localparam int unsigned FracW     = 8;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned DivSteps  = RateW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [PeriodW-1:0]  PeriodReset  = PeriodW'(5);
  localparam logic [SpacingW-1:0] SpacingReset = SpacingW'(20);
  localparam logic [RateW-1:0]    RateSat      = {RateW{1'b1}};
  localparam logic [ElapsedW-1:0] ElapsedSat   = {ElapsedW{1'b1}};

  localparam logic CfgPeriod  = 1'b0;
  localparam logic CfgSpacing = 1'b1;

  typedef enum logic [2:0] {
    DIR_ON_LINE,
    DIR_ONE_OFF_RIGHT,
    DIR_BOTH_OFF_RIGHT,
    DIR_ONE_OFF_LEFT,
    DIR_BOTH_OFF_LEFT
  } dir_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/ldt_ctrl.sv =====
// Controller state machine sequencing load, rate division and result hand-off.
module ldt_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ldt_pkg::sts_t sts_i,
  output ldt_pkg::cmd_t cmd_o
);
  import ldt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.need_div ? S_DIV : S_PUSH;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DIV:  cmd_o.step = 1'b1;
      S_PUSH: cmd_o.push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/ldt_dp.sv =====
// Datapath: tracker state, sample gate, serial rate divider and result register.
module ldt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [ldt_pkg::PeriodW-1:0]   cfg_data_i,
  input  logic [ldt_pkg::InDataW-1:0]   in_data_i,
  output logic [ldt_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  ldt_pkg::cmd_t                 cmd_i,
  output ldt_pkg::sts_t                 sts_o
);
  import ldt_pkg::*;

  logic [PeriodW-1:0]  period_q;
  logic [SpacingW-1:0] spacing_q;
  dir_e                dir_q, dir_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [RateW-1:0]    rate_q, rate_d;
  logic [TimeW-1:0]    last_q;
  logic                sampled_q;
  logic [RateW-1:0]    quo_q;
  logic [SpacingW-1:0] rem_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [TimeW-1:0]    now;
  logic                left_on, right_on;
  logic                gate;
  logic                latch;
  logic [ElapsedW:0]   sum;
  logic [SpacingW:0]   trial;
  logic                qbit;
  logic [TimeW-1:0]    diff;

  assign now      = in_data_i[TimeW-1:0];
  assign left_on  = in_data_i[TimeW];
  assign right_on = in_data_i[TimeW+1];
  assign diff     = now - last_q;
  assign gate     = diff > TimeW'(period_q);
  assign sum      = {1'b0, elapsed_q} + (ElapsedW+1)'(period_q);

  always_comb begin
    dir_d     = dir_q;
    elapsed_d = elapsed_q;
    rate_d    = rate_q;
    latch     = 1'b0;
    if (gate) begin
      if (left_on && right_on) begin
        dir_d     = DIR_ON_LINE;
        elapsed_d = '0;
        rate_d    = '0;
      end else begin
        elapsed_d = sum[ElapsedW] ? ElapsedSat : sum[ElapsedW-1:0];
        if (left_on) begin
          dir_d = DIR_ONE_OFF_RIGHT;
        end else if (!right_on && dir_d == DIR_ONE_OFF_RIGHT) begin
          dir_d = DIR_BOTH_OFF_RIGHT;
          latch = rate_q == '0;
        end
        if (right_on) begin
          dir_d = DIR_ONE_OFF_LEFT;
        end else if (!left_on && dir_d == DIR_ONE_OFF_LEFT) begin
          dir_d = DIR_BOTH_OFF_LEFT;
          latch = rate_q == '0;
        end
        if (latch && spacing_q == '0) begin
          rate_d = RateSat;
        end
      end
    end
  end

  assign trial = {rem_q, quo_q[RateW-1]};
  assign qbit  = trial >= (SpacingW+1)'(spacing_q);

  assign sts_o.need_div = latch && spacing_q != '0;
  assign sts_o.div_last = cnt_q == DivCntW'(DivSteps - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodReset;
      spacing_q <= SpacingReset;
      dir_q     <= DIR_ON_LINE;
      elapsed_q <= '0;
      rate_q    <= '0;
      last_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgPeriod) begin
          period_q <= cfg_data_i;
        end else begin
          spacing_q <= cfg_data_i;
        end
      end
      if (cmd_i.load) begin
        dir_q     <= dir_d;
        elapsed_q <= elapsed_d;
        rate_q    <= rate_d;
        if (gate) begin
          last_q <= now;
        end
      end else if (cmd_i.step && sts_o.div_last) begin
        rate_q <= {quo_q[RateW-2:0], qbit};
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sampled_q <= gate;
      quo_q     <= {elapsed_d, {FracW{1'b0}}};
      rem_q     <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[RateW-2:0], qbit};
      rem_q <= qbit ? SpacingW'(trial - (SpacingW+1)'(spacing_q)) : trial[SpacingW-1:0];
      cnt_q <= cnt_q + DivCntW'(1);
    end
    if (cmd_i.push) begin
      out_data_q <= {4'b0000, sampled_q, rate_q, elapsed_q, dir_q};
    end
  end

  assign out_data_o  = out_data_q;
  assign out_valid_o = out_valid_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a beat not yet taken");

  a_rate_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.load && !cmd_i.step) |=> $stable(rate_q))
    else $error("rate changed outside load or division");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q < DivCntW'(DivSteps))
    else $error("divider ran past its last step");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && (cmd_i.step || cmd_i.push)))
    else $error("load issued together with step or push");

endmodule

// ===== sv/line_departure_tracker_core.sv =====
// Top level of the line departure tracker: controller, datapath and ports.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o now_ms, left_on, right_on
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i direction, elapsed_ms,
//                                                       departure_rate, sampled
//  cfg       in         cfg_valid_i/cfg_ready_o         cfg_index_i, cfg_data_i
//
// An item's result is loaded into the output register once that register is free; if
// the item latches a new rate from a nonzero spacing, the 24-step restoring divider,
// which yields one quotient bit per cycle, runs first. One item is in work at a time;
// the next is taken as soon as its result sits in the output register, even if that
// beat is still stalled, while a beat still waiting there holds off the following one.
// Reset restores the register defaults and clears all tracker state.
module line_departure_tracker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] now_ms, [32] left_on, [33] right_on, [39:34] zero
  input  logic [ldt_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] direction, [18:3] elapsed_ms, [42:19] departure_rate, [43] sampled,
  // [47:44] zero
  output logic [ldt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [ldt_pkg::PeriodW-1:0]   cfg_data_i
);
  import ldt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ldt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ldt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
